>>> rtl/array_linked_list_manager_top_assert.svh
// assertion macros for the list manager top level
`ifndef ARRAY_LINKED_LIST_MANAGER_TOP_ASSERT_SVH
`define ARRAY_LINKED_LIST_MANAGER_TOP_ASSERT_SVH

// same-cycle implication
`define ALLM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allm assertion failed");

// next-cycle implication
`define ALLM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allm assertion failed");

`endif

>>> rtl/allm_pkg.sv
package allm_pkg;

    localparam int SLOTS      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = $clog2(SLOTS);

    localparam int KIND_W  = 3;
    localparam int POS_W   = 8;
    localparam int VALUE_W = 32;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 8;

    localparam logic [KIND_W-1:0] KIND_INS_AFTER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_BEFORE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_LIVE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE1,
        S_WRITE2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic init;
        logic load_op;
        logic rd1;
        logic chk;
        logic wr1;
        logic wr2;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic init_last;
    } t_dp_sts;

    // free chain after reset: ascending, last slot ends it, sentinel to itself
    function automatic logic [SLOT_W-1:0] next_rst(input logic [SLOT_W-1:0] addr);
        logic [SLOT_W-1:0] res;
        if (addr == '0 || addr == SLOT_W'(SLOTS - 1)) begin
            res = '0;
        end else begin
            res = addr + 1'b1;
        end
        return res;
    endfunction

    function automatic logic live_rst(input logic [SLOT_W-1:0] addr);
        return addr == '0;
    endfunction

endpackage

>>> rtl/allm_if.sv
interface allm_in_if import allm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    position;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

interface allm_out_if import allm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [POS_W-1:0]  slot;
    logic [CNT_W-1:0]  count;

    modport source (output valid, status, slot, count, input ready);
    modport sink   (input valid, status, slot, count, output ready);
endinterface

>>> rtl/allm_ram.sv
module allm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/allm_ctrl.sv
module allm_ctrl import allm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && !i_out_ready;
        o_cmd     = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_op = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.err ? S_DONE : S_WRITE1;
            end
            S_WRITE1: begin
                o_cmd.wr1 = 1'b1;
                n_state   = S_WRITE2;
            end
            S_WRITE2: begin
                o_cmd.wr2 = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // previous result must be gone before the new one is loaded
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

>>> rtl/allm_dp.sv
module allm_dp import allm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [POS_W-1:0]   i_pos,
    input  logic [VALUE_W-1:0] i_value,
    output logic [ST_W-1:0]    o_status,
    output logic [POS_W-1:0]   o_slot,
    output logic [CNT_W-1:0]   o_count
);

    // operation
    logic [KIND_W-1:0]  r_kind;
    logic [POS_W-1:0]   r_pos;
    logic [VALUE_W-1:0] r_value;
    logic               r_pos_ok;

    // list state
    logic [SLOT_W-1:0]  r_free;
    logic [SLOT_W-1:0]  r_count;
    logic [SLOT_W-1:0]  r_init_addr;

    // working registers
    logic [SLOT_W-1:0]  r_a;
    logic [SLOT_W-1:0]  r_n;
    logic [SLOT_W-1:0]  r_fnext;
    logic [SLOT_W-1:0]  r_slot;
    logic [ST_W-1:0]    r_st;
    logic               r_is_del;

    // result register
    logic [ST_W-1:0]    r_o_status;
    logic [POS_W-1:0]   r_o_slot;
    logic [CNT_W-1:0]   r_o_count;

    logic                  nxt_we, prv_we, live_we, elem_we;
    logic [SLOT_W-1:0]     nxt_wa, prv_wa, live_wa;
    logic [SLOT_W-1:0]     nxt_wd, prv_wd;
    logic                  live_wd;
    logic                  nxt_re, prv_re, live_re;
    logic [SLOT_W-1:0]     nxt_ra, prv_ra, live_ra;
    logic [SLOT_W-1:0]     nxt_ram_q, prv_ram_q;
    logic                  live_ram_q;
    logic [SLOT_W-1:0]     nxt_q, prv_q;
    logic                  live_q;
    logic [SLOT_W-1:0]     pos_s;
    logic [SLOT_W-1:0]     anchor;
    logic [ST_W-1:0]       chk_st;
    logic                  live_ok;
    logic                  no_free;

    allm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_wa),
        .i_wdata (nxt_wd),
        .i_re    (nxt_re),
        .i_raddr (nxt_ra),
        .o_rdata (nxt_ram_q)
    );

    allm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_wa),
        .i_wdata (prv_wd),
        .i_re    (prv_re),
        .i_raddr (prv_ra),
        .o_rdata (prv_ram_q)
    );

    allm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (live_we),
        .i_waddr (live_wa),
        .i_wdata (live_wd),
        .i_re    (live_re),
        .i_raddr (live_ra),
        .o_rdata (live_ram_q)
    );

    allm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (r_free),
        .i_wdata (DATA_WIDTH'(r_value)),
        .i_re    (1'b0),
        .i_raddr (r_free),
        .o_rdata ()
    );

    assign pos_s  = SLOT_W'(r_pos);
    assign nxt_q  = nxt_ram_q;
    assign prv_q  = prv_ram_q;
    assign live_q = live_ram_q;

    assign live_ok = r_pos_ok && live_q;
    assign no_free = (r_free == '0);

    // anchor slot and check outcome
    always_comb begin
        anchor = '0;
        chk_st = ST_NOT_LIVE;
        unique case (r_kind) inside
            KIND_INS_AFTER: begin
                anchor = pos_s;
                chk_st = !live_ok ? ST_NOT_LIVE : (no_free ? ST_FULL : ST_OK);
            end
            KIND_INS_BEFORE: begin
                anchor = prv_q;
                chk_st = !live_ok ? ST_NOT_LIVE : (no_free ? ST_FULL : ST_OK);
            end
            KIND_DELETE: begin
                anchor = prv_q;
                chk_st = (r_pos == '0 || !live_ok) ? ST_NOT_LIVE : ST_OK;
            end
            KIND_PUSH_FRONT: begin
                anchor = '0;
                chk_st = no_free ? ST_FULL : ST_OK;
            end
            KIND_PUSH_BACK: begin
                anchor = prv_q;
                chk_st = no_free ? ST_FULL : ST_OK;
            end
            default: begin
                anchor = '0;
                chk_st = ST_NOT_LIVE;
            end
        endcase
    end

    assign o_sts = '{err: (chk_st != ST_OK),
                     init_last: (r_init_addr == SLOT_W'(SLOTS - 1))};

    // memory port control
    always_comb begin
        nxt_re  = 1'b0;
        prv_re  = 1'b0;
        live_re = 1'b0;
        nxt_ra  = r_free;
        prv_ra  = pos_s;
        live_ra = pos_s;
        nxt_we  = 1'b0;
        prv_we  = 1'b0;
        live_we = 1'b0;
        elem_we = 1'b0;
        nxt_wa  = r_a;
        nxt_wd  = r_free;
        prv_wa  = r_n;
        prv_wd  = r_free;
        live_wa = r_free;
        live_wd = 1'b1;
        // clearing pass writes the reset pattern one slot a cycle
        if (i_cmd.init) begin
            nxt_we  = 1'b1;
            prv_we  = 1'b1;
            live_we = 1'b1;
            nxt_wa  = r_init_addr;
            nxt_wd  = next_rst(r_init_addr);
            prv_wa  = r_init_addr;
            prv_wd  = '0;
            live_wa = r_init_addr;
            live_wd = live_rst(r_init_addr);
        end
        if (i_cmd.rd1) begin
            nxt_re  = 1'b1;
            prv_re  = 1'b1;
            live_re = 1'b1;
            nxt_ra  = (r_kind == KIND_DELETE) ? pos_s : r_free;
            prv_ra  = (r_kind == KIND_PUSH_BACK) ? '0 : pos_s;
        end
        if (i_cmd.chk) begin
            nxt_re = 1'b1;
            nxt_ra = anchor;
        end
        if (i_cmd.wr1) begin
            nxt_we  = 1'b1;
            prv_we  = 1'b1;
            live_we = 1'b1;
            if (r_is_del) begin
                nxt_wa  = r_a;
                nxt_wd  = r_n;
                prv_wa  = r_n;
                prv_wd  = r_a;
                live_wa = pos_s;
                live_wd = 1'b0;
            end else begin
                elem_we = 1'b1;
                nxt_wa  = r_free;
                nxt_wd  = nxt_q;
                prv_wa  = r_free;
                prv_wd  = r_a;
                live_wa = r_free;
                live_wd = 1'b1;
            end
        end
        if (i_cmd.wr2) begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
            if (r_is_del) begin
                prv_wa = pos_s;
                prv_wd = '0;
                nxt_wa = pos_s;
                nxt_wd = r_free;
            end else begin
                prv_wa = r_n;
                prv_wd = r_free;
                nxt_wa = r_a;
                nxt_wd = r_free;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= SLOT_W'(1);
            r_count     <= '0;
            r_init_addr <= '0;
        end else begin
            if (i_cmd.init) begin
                r_init_addr <= r_init_addr + 1'b1;
            end
            if (i_cmd.wr2) begin
                if (r_is_del) begin
                    r_free  <= pos_s;
                    r_count <= r_count - 1'b1;
                end else begin
                    r_free  <= r_fnext;
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_op) begin
            r_kind   <= i_kind;
            r_pos    <= i_pos;
            r_value  <= i_value;
            r_pos_ok <= (32'(i_pos) < 32'(SLOTS));
        end
        if (i_cmd.chk) begin
            r_a      <= anchor;
            r_n      <= nxt_q;
            r_fnext  <= nxt_q;
            r_st     <= chk_st;
            r_is_del <= (r_kind == KIND_DELETE);
            if (chk_st != ST_OK) begin
                r_slot <= '0;
            end else if (r_kind == KIND_DELETE) begin
                r_slot <= pos_s;
            end else begin
                r_slot <= r_free;
            end
        end
        if (i_cmd.wr1 && !r_is_del) begin
            r_n <= nxt_q;
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_st;
            r_o_slot   <= POS_W'(r_slot);
            r_o_count  <= CNT_W'(r_count);
        end
    end

    assign o_status = r_o_status;
    assign o_slot   = r_o_slot;
    assign o_count  = r_o_count;

endmodule

>>> rtl/array_linked_list_manager_top.sv
// channel  | dir | payload                 | transfer when
// i_in     | in  | kind, position, value   | valid && ready
// o_res    | out | status, slot, count     | valid && ready
//
// each operation takes the item, reads the links, reads the anchor's next
// link, writes twice on the single write port of each link store, then loads
// the result; a rejected one skips the writes.
// after reset a clearing pass writes every slot of the link and live stores
// and holds off the input until it ends.
// a result not yet taken holds the block before it loads the next one.
`include "array_linked_list_manager_top_assert.svh"

module array_linked_list_manager_top import allm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    allm_in_if.sink    i_in,
    allm_out_if.source o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    allm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    allm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_kind   (i_in.kind),
        .i_pos    (i_in.position),
        .i_value  (i_in.value),
        .o_status (o_res.status),
        .o_slot   (o_res.slot),
        .o_count  (o_res.count)
    );

    `ALLM_ASSERT_NXT(a_busy_after_take, i_in.valid && i_in.ready, !i_in.ready)
    `ALLM_ASSERT_IMP(a_one_step, 1'b1, $onehot0(cmd))
    `ALLM_ASSERT_NXT(a_result_shown, cmd.load_out, o_res.valid)
    `ALLM_ASSERT_IMP(a_ok_slot, o_res.valid && o_res.status == ST_OK, o_res.slot != '0)
    `ALLM_ASSERT_IMP(a_err_slot, o_res.valid && o_res.status != ST_OK, o_res.slot == '0)

endmodule

>>> sim/array_linked_list_manager_top_tb.sv
`timescale 1ns / 100ps

module array_linked_list_manager_top_tb;
    import allm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int NUM_DIRECTED = 19;
    localparam int NUM_PHASES = 5;
    localparam int HOLD_AFTER = 400;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] slot;
        logic [CNT_W-1:0] count;
    } t_list_result;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        logic               typed;
        t_list_result       res;
    } t_list_row;

    // expected results are filled in where they follow directly from reset state
    localparam t_list_row DIRECTED_OPS [NUM_DIRECTED] = '{
        '{KIND_DELETE,     8'd0,   32'h0000_0000, 1'b1, '{ST_NOT_LIVE, 8'd0, 8'd0}},
        '{KIND_INS_AFTER,  8'd5,   32'h0000_0001, 1'b1, '{ST_NOT_LIVE, 8'd0, 8'd0}},
        '{KIND_INS_BEFORE, 8'd255, 32'h0000_0002, 1'b1, '{ST_NOT_LIVE, 8'd0, 8'd0}},
        '{KIND_SPARE_LO,   8'd0,   32'h0000_0003, 1'b1, '{ST_NOT_LIVE, 8'd0, 8'd0}},
        '{KIND_SPARE_HI,   8'd255, 32'hFFFF_FFFF, 1'b1, '{ST_NOT_LIVE, 8'd0, 8'd0}},
        '{KIND_PUSH_FRONT, 8'd0,   32'h0000_0000, 1'b1, '{ST_OK, 8'd1, 8'd1}},
        '{KIND_PUSH_BACK,  8'd255, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 8'd2, 8'd2}},
        '{KIND_INS_AFTER,  8'd0,   32'hAAAA_5555, 1'b1, '{ST_OK, 8'd3, 8'd3}},
        '{KIND_INS_BEFORE, 8'd0,   32'h5555_AAAA, 1'b1, '{ST_OK, 8'd4, 8'd4}},
        '{KIND_INS_AFTER,  8'd1,   32'h1234_5678, 1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{KIND_INS_BEFORE, 8'd2,   32'h8765_4321, 1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{KIND_DELETE,     8'd3,   32'h0000_0000, 1'b1, '{ST_OK, 8'd3, 8'd5}},
        '{KIND_PUSH_BACK,  8'd128, 32'hDEAD_BEEF, 1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{KIND_DELETE,     8'd255, 32'h0000_0000, 1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{KIND_SPARE_MID,  8'd128, 32'h7FFF_FFFF, 1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{KIND_DELETE,     8'd1,   32'h0000_0000, 1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{KIND_DELETE,     8'd1,   32'h0000_0000, 1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{KIND_INS_AFTER,  8'd1,   32'h8000_0000, 1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{KIND_PUSH_FRONT, 8'd77,  32'h8000_0001, 1'b0, '{ST_OK, 8'd0, 8'd0}}
    };

    // percentage of inserts and length of each random phase
    localparam int PHASE_INSERT_PCT [NUM_PHASES] = '{90, 10, 50, 90, 10};
    localparam int PHASE_ITEMS      [NUM_PHASES] = '{400, 300, 350, 350, 250};

    logic i_clk;
    logic i_rst_n;

    allm_in_if  in_if ();
    allm_out_if res_if ();

    array_linked_list_manager_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    logic [POS_W-1:0] next_link [SLOTS];
    logic [POS_W-1:0] prev_link [SLOTS];
    logic             live_mark [SLOTS];
    logic [POS_W-1:0] free_slot_head;
    logic [CNT_W-1:0] live_count;

    t_list_result expected_results [$];
    int error_count;
    int items_sent;
    int results_checked;
    int ok_seen;
    int not_live_seen;
    int full_seen;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic clear_list();
        for (int i = 0; i < SLOTS; i++) begin
            next_link[i] = (i + 1 < SLOTS) ? POS_W'(i + 1) : '0;
            prev_link[i] = '0;
            live_mark[i] = 1'b0;
        end
        next_link[0] = '0;
        live_mark[0] = 1'b1;
        free_slot_head = 8'd1;
        live_count = '0;
    endtask

    task automatic link_fresh(input logic [POS_W-1:0] anchor, inout t_list_result res);
        logic [POS_W-1:0] s;
        logic [POS_W-1:0] n;
        if (free_slot_head == '0) begin
            res.status = ST_FULL;
        end else begin
            s = free_slot_head;
            free_slot_head = next_link[s];
            n = next_link[anchor];
            next_link[s] = n;
            prev_link[s] = anchor;
            prev_link[n] = s;
            next_link[anchor] = s;
            live_mark[s] = 1'b1;
            live_count++;
            res.status = ST_OK;
            res.slot = s;
        end
    endtask

    task automatic unlink_slot(input logic [POS_W-1:0] p, inout t_list_result res);
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] n;
        a = prev_link[p];
        n = next_link[p];
        next_link[a] = n;
        prev_link[n] = a;
        live_mark[p] = 1'b0;
        prev_link[p] = '0;
        next_link[p] = free_slot_head;
        free_slot_head = p;
        live_count--;
        res.status = ST_OK;
        res.slot = p;
    endtask

    task automatic predict_list_op(input logic [KIND_W-1:0] kind,
                                   input logic [POS_W-1:0] pos,
                                   output t_list_result res);
        res = '{ST_NOT_LIVE, 8'd0, 8'd0};
        case (kind)
            KIND_INS_AFTER: begin
                if (live_mark[pos]) link_fresh(pos, res);
            end
            KIND_INS_BEFORE: begin
                if (live_mark[pos]) link_fresh(prev_link[pos], res);
            end
            KIND_DELETE: begin
                if (pos != '0 && live_mark[pos]) unlink_slot(pos, res);
            end
            KIND_PUSH_FRONT: begin
                link_fresh('0, res);
            end
            KIND_PUSH_BACK: begin
                link_fresh(prev_link[0], res);
            end
            default: begin
            end
        endcase
        if (res.status != ST_OK) res.slot = '0;
        res.count = live_count;
    endtask

    function automatic logic [POS_W-1:0] pick_live(input bit with_sentinel);
        int start;
        int idx;
        logic [POS_W-1:0] found;
        start = $urandom_range(0, SLOTS - 1);
        found = '0;
        for (int i = 0; i < SLOTS; i++) begin
            idx = (start + i) % SLOTS;
            if (live_mark[idx] && (with_sentinel || idx != 0)) begin
                found = POS_W'(idx);
                break;
            end
        end
        return found;
    endfunction

    // one transfer on the input channel, then the prediction for it
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] value, input bit typed,
                           input t_list_result typed_res, input bit no_gaps);
        int gap;
        t_list_result predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.kind     <= kind;
        in_if.position <= pos;
        in_if.value    <= value;
        in_if.valid    <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        predict_list_op(kind, pos, predicted);
        expected_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, got_val);
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing expected, status %0d slot %0d count %0d",
                         $time, res_if.status, res_if.slot, res_if.count);
            end else begin
                exp_res = expected_results.pop_front();
                check_field("status", int'(exp_res.status), int'(res_if.status));
                check_field("slot", int'(exp_res.slot), int'(res_if.slot));
                check_field("count", int'(exp_res.count), int'(res_if.count));
                results_checked++;
                case (exp_res.status)
                    ST_OK:       ok_seen++;
                    ST_NOT_LIVE: not_live_seen++;
                    ST_FULL:     full_seen++;
                    default: ;
                endcase
            end
        end
    end

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int gap;
        int taken;
        taken = 0;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (taken == HOLD_AFTER) gap = HOLD_CYCLES;
            else if ((taken / 64) % 4 == 2) gap = 0;
            else gap = $urandom_range(0, 4);
            if (gap > 0) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            taken++;
        end
    end

    initial begin
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        int r;
        int n;
        bit calm;
        error_count = 0;
        items_sent = 0;
        results_checked = 0;
        ok_seen = 0;
        not_live_seen = 0;
        full_seen = 0;
        in_if.valid = 1'b0;
        in_if.kind = '0;
        in_if.position = '0;
        in_if.value = '0;
        i_rst_n = 1'b0;
        clear_list();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_op(DIRECTED_OPS[i].kind, DIRECTED_OPS[i].position, DIRECTED_OPS[i].value,
                    DIRECTED_OPS[i].typed, DIRECTED_OPS[i].res, 1'b0);

        n = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int i = 0; i < PHASE_ITEMS[ph]; i++) begin
                r = $urandom_range(0, 99);
                value = $urandom();
                if (r < 5) begin
                    // noise: any kind, any slot
                    kind = KIND_W'($urandom_range(0, KIND_SPARE_HI));
                    pos = POS_W'($urandom_range(0, SLOTS - 1));
                end else if ($urandom_range(0, 99) < PHASE_INSERT_PCT[ph]) begin
                    case ($urandom_range(0, 3))
                        0: kind = KIND_INS_AFTER;
                        1: kind = KIND_INS_BEFORE;
                        2: kind = KIND_PUSH_FRONT;
                        default: kind = KIND_PUSH_BACK;
                    endcase
                    if (kind == KIND_INS_AFTER || kind == KIND_INS_BEFORE)
                        pos = pick_live(1'b1);
                    else
                        pos = POS_W'($urandom_range(0, SLOTS - 1));
                end else begin
                    kind = KIND_DELETE;
                    pos = pick_live(1'b0);
                end
                calm = ((n / 64) % 4 == 3);
                send_op(kind, pos, value, 1'b0, '0, calm);
                n++;
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("tb: %0d list operations sent, %0d results checked", items_sent,
                 results_checked);
        $display("tb: ok %0d, slot not live %0d, list full %0d, mismatches %0d",
                 ok_seen, not_live_seen, full_seen, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
